@@ hdl/xgcd_pkg.sv @@
// shared types, constants and the control program of the modular inverse sequencer
package xgcd_pkg;

  localparam int XGCD_WIDTH = 32;
  localparam int STEP_W     = 4;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MULX,
    OP_UPDX,
    OP_UPDY,
    OP_FIX_NEG,
    OP_FIX_HIGH,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_CUR_ZERO,
    C_DIV_MORE,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    op_t op;
  } ctrl_t;

  typedef struct packed {
    logic cur_zero;
    logic div_more;
    logic out_busy;
  } status_t;

  // program addresses
  localparam step_t S_WAIT     = step_t'(0);
  localparam step_t S_TEST     = step_t'(1);
  localparam step_t S_DIV_INIT = step_t'(2);
  localparam step_t S_DIV_STEP = step_t'(3);
  localparam step_t S_MULX     = step_t'(4);
  localparam step_t S_UPDX     = step_t'(5);
  localparam step_t S_UPDY     = step_t'(6);
  localparam step_t S_FIX_NEG  = step_t'(7);
  localparam step_t S_FIX_HIGH = step_t'(8);
  localparam step_t S_EMIT     = step_t'(9);
  localparam step_t S_HOLD     = step_t'(10);

  // control store: a taken condition jumps to target, otherwise fall through
  function automatic ucode_t ucode_rom(input step_t pc);
    ucode_t w;
    unique case (pc)
      S_WAIT:     w = '{op: OP_LOAD,     cond: C_NO_INPUT, target: S_WAIT};
      S_TEST:     w = '{op: OP_NOP,      cond: C_CUR_ZERO, target: S_FIX_NEG};
      S_DIV_INIT: w = '{op: OP_DIV_INIT, cond: C_NEXT,     target: S_WAIT};
      S_DIV_STEP: w = '{op: OP_DIV_STEP, cond: C_DIV_MORE, target: S_DIV_STEP};
      S_MULX:     w = '{op: OP_MULX,     cond: C_NEXT,     target: S_WAIT};
      S_UPDX:     w = '{op: OP_UPDX,     cond: C_NEXT,     target: S_WAIT};
      S_UPDY:     w = '{op: OP_UPDY,     cond: C_ALWAYS,   target: S_TEST};
      S_FIX_NEG:  w = '{op: OP_FIX_NEG,  cond: C_NEXT,     target: S_WAIT};
      S_FIX_HIGH: w = '{op: OP_FIX_HIGH, cond: C_NEXT,     target: S_WAIT};
      S_EMIT:     w = '{op: OP_EMIT,     cond: C_OUT_FREE, target: S_WAIT};
      S_HOLD:     w = '{op: OP_NOP,      cond: C_ALWAYS,   target: S_EMIT};
      default:    w = '{op: OP_NOP,      cond: C_ALWAYS,   target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

@@ hdl/xgcd_sequencer.sv @@
// step counter and control store of the modular inverse sequencer
module xgcd_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  xgcd_pkg::status_t status,
  output xgcd_pkg::ctrl_t   ctrl,
  output logic              in_ready
);
  import xgcd_pkg::*;

  step_t  pc_r;
  step_t  pc_nxt;
  ucode_t uw;
  logic   taken;

  assign uw = ucode_rom(pc_r);

  always_comb begin
    unique case (uw.cond)
      C_NEXT:     taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_NO_INPUT: taken = !in_valid;
      C_CUR_ZERO: taken = status.cur_zero;
      C_DIV_MORE: taken = status.div_more;
      C_OUT_FREE: taken = !status.out_busy;
      default:    taken = 1'b1;
    endcase
    pc_nxt = taken ? uw.target : pc_r + step_t'(1);
  end

  always_comb begin
    ctrl.op  = uw.op;
    in_ready = (pc_r == S_WAIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

@@ hdl/xgcd_datapath.sv @@
// remainders, coefficients, shift-subtract divider, shared multiplier and output word
module xgcd_datapath #(
  parameter int WIDTH = xgcd_pkg::XGCD_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  xgcd_pkg::ctrl_t         ctrl,
  output xgcd_pkg::status_t       status,
  input  logic                    in_valid,
  input  logic [WIDTH-2:0]        in_value,
  input  logic [WIDTH-2:0]        in_modulus,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [WIDTH-2:0]        out_divisor,
  output logic signed [WIDTH-1:0] out_coeff_value,
  output logic signed [WIDTH-1:0] out_coeff_modulus,
  output logic [WIDTH-2:0]        out_inverse_value,
  output logic                    out_no_inverse
);
  import xgcd_pkg::*;

  localparam int OW = WIDTH - 1;
  localparam int CW = $clog2(OW);

  logic [OW-1:0]    cur_r, cur_nxt, prev_r, prev_nxt, n_r, n_nxt;
  logic [OW-1:0]    rem_r, rem_nxt, quo_r, quo_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [WIDTH-1:0] cx_r, cx_nxt, px_r, px_nxt, cy_r, cy_nxt, py_r, py_nxt;
  logic [WIDTH-1:0] prod_r, prod_nxt, inv_r, inv_nxt;
  logic [WIDTH-1:0] trial, trial_diff, n_ext, mul_a, mul_b;
  logic [2*WIDTH-1:0] prod_full;
  logic             ge, none;
  logic             out_valid_r, out_valid_nxt, emit;
  logic [OW-1:0]    odiv_r, oinv_r;
  logic [WIDTH-1:0] ocx_r, ocy_r;
  logic             onone_r;

  assign n_ext      = {1'b0, n_r};
  assign trial      = {rem_r, quo_r[OW-1]};
  assign trial_diff = trial - {1'b0, cur_r};
  assign ge         = (trial >= {1'b0, cur_r});
  assign mul_a      = {1'b0, quo_r};
  assign mul_b      = (ctrl.op == OP_UPDX) ? cy_r : cx_r;
  assign prod_full  = mul_a * mul_b;
  assign none       = (n_r == '0) || (prev_r != OW'(1));

  assign status.cur_zero = (cur_r == '0);
  assign status.div_more = (cnt_r != CW'(OW - 1));
  assign status.out_busy = out_valid_r && !out_ready;
  assign emit = (ctrl.op == OP_EMIT) && !status.out_busy;

  always_comb begin
    cur_nxt  = cur_r;
    prev_nxt = prev_r;
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    cx_nxt   = cx_r;
    px_nxt   = px_r;
    cy_nxt   = cy_r;
    py_nxt   = py_r;
    prod_nxt = prod_r;
    inv_nxt  = inv_r;
    case (ctrl.op)
      OP_LOAD: begin
        if (in_valid) begin
          cur_nxt  = in_value;
          prev_nxt = in_modulus;
          n_nxt    = in_modulus;
          cx_nxt   = WIDTH'(1);
          px_nxt   = '0;
          cy_nxt   = '0;
          py_nxt   = WIDTH'(1);
        end
      end
      OP_DIV_INIT: begin
        rem_nxt = '0;
        quo_nxt = prev_r;
        cnt_nxt = '0;
      end
      OP_DIV_STEP: begin
        // one quotient bit per cycle, dividend bits shift out as quotient bits shift in
        rem_nxt = ge ? trial_diff[OW-1:0] : trial[OW-1:0];
        quo_nxt = {quo_r[OW-2:0], ge};
        cnt_nxt = cnt_r + CW'(1);
      end
      OP_MULX: begin
        prod_nxt = prod_full[WIDTH-1:0];
      end
      OP_UPDX: begin
        px_nxt   = cx_r;
        cx_nxt   = px_r - prod_r;
        prod_nxt = prod_full[WIDTH-1:0];
      end
      OP_UPDY: begin
        py_nxt   = cy_r;
        cy_nxt   = py_r - prod_r;
        prev_nxt = cur_r;
        cur_nxt  = rem_r;
      end
      OP_FIX_NEG: begin
        inv_nxt = px_r[WIDTH-1] ? px_r + n_ext : px_r;
      end
      OP_FIX_HIGH: begin
        if (inv_r >= n_ext) begin
          inv_nxt = inv_r - n_ext;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    cx_r   <= cx_nxt;
    px_r   <= px_nxt;
    cy_r   <= cy_nxt;
    py_r   <= py_nxt;
    prod_r <= prod_nxt;
    inv_r  <= inv_nxt;
    if (emit) begin
      odiv_r  <= prev_r;
      ocx_r   <= px_r;
      ocy_r   <= py_r;
      onone_r <= none;
      oinv_r  <= none ? '0 : inv_r[OW-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_divisor       = odiv_r;
  assign out_coeff_value   = ocx_r;
  assign out_coeff_modulus = ocy_r;
  assign out_inverse_value = oinv_r;
  assign out_no_inverse    = onone_r;

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("emitted word not presented");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_DIV_STEP && !status.div_more) |=> (rem_r < cur_r))
    else $error("division remainder not below divisor");

  a_inverse_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_FIX_HIGH && n_r != '0 && prev_r == OW'(1)) |=> (inv_r < n_ext))
    else $error("inverse not reduced below modulus");

endmodule

@@ hdl/modular_inverse_xgcd.sv @@
// modular inverse by the extended euclidean algorithm, top level
// Usage: present in_value and in_modulus on the input channel (valid/ready).
// One result word follows on the output channel for every accepted input word:
// the gcd, both signed Bezout coefficients, the inverse of value modulo
// modulus in 0..modulus-1, and no_inverse, set when the gcd is not 1 or the
// modulus is zero (inverse then reads 0).
// A microcoded sequencer runs one word at a time; in_ready is high only while
// it waits at the start of its program. Each euclid step runs a test, a
// divider setup, a shift-subtract step of the divider per quotient bit, a
// multiply and the updates of both coefficient pairs on the shared
// multiplier and coefficient adders. The number of euclid steps is at most
// about 46 for 31-bit operands; a value of zero takes no step. in_ready
// rises together with out_valid, so a new word is taken only once the last
// result has been emitted. The result sits in an output register, so a
// stalled receiver holds the sequencer only at its final step; the next
// word is taken once the result is written out. Reset clears the sequencer
// and the output valid bit.
module modular_inverse_xgcd #(
  parameter int WIDTH = xgcd_pkg::XGCD_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [WIDTH-2:0]        in_value,
  input  logic [WIDTH-2:0]        in_modulus,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [WIDTH-2:0]        out_divisor,
  output logic signed [WIDTH-1:0] out_coeff_value,
  output logic signed [WIDTH-1:0] out_coeff_modulus,
  output logic [WIDTH-2:0]        out_inverse_value,
  output logic                    out_no_inverse
);
  import xgcd_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  xgcd_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .ctrl     (ctrl),
    .in_ready (in_ready)
  );

  xgcd_datapath #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .status            (status),
    .in_valid          (in_valid),
    .in_value          (in_value),
    .in_modulus        (in_modulus),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_divisor       (out_divisor),
    .out_coeff_value   (out_coeff_value),
    .out_coeff_modulus (out_coeff_modulus),
    .out_inverse_value (out_inverse_value),
    .out_no_inverse    (out_no_inverse)
  );

endmodule
